// ----- hdl/ps2km_pkg.sv -----
// Shared constants for the PS/2 set-2 scan code key matrix.
// Holds scan code values, the row key table and item codes.
// No dependencies.
package ps2km_pkg;

    // Item kinds carried on the input tuser bit.
    localparam logic OP_CODE = 1'b0;
    localparam logic OP_ROW  = 1'b1;

    // Field widths.
    localparam int CODE_W     = 8;
    localparam int ROW_W      = 3;
    localparam int ROW_BITS_W = 13;
    localparam int LAST_KEY_W = 9;

    // Default depth of the key-down map.
    localparam int KEY_MAP_DEPTH_DEF = 256;

    // Special scan code bytes and keys.
    localparam logic [CODE_W-1:0] CODE_EXTENDED = 8'hE0;
    localparam logic [CODE_W-1:0] CODE_RELEASE  = 8'hF0;
    localparam logic [CODE_W-1:0] CODE_NONE     = 8'h00;
    localparam logic [CODE_W-1:0] KEY_LOW_MASK  = 8'h7F;
    localparam logic [CODE_W-1:0] KEY_EXT_BIT   = 8'h80;
    localparam logic [CODE_W-1:0] KEY_CTRL      = 8'h14;
    localparam logic [CODE_W-1:0] KEY_ESC       = 8'h76;
    localparam logic [CODE_W-1:0] KEY_RSHIFT    = 8'h59;

    // Right shift shares a bit of the last defined row.
    localparam logic [ROW_W-1:0] RSHIFT_ROW = 3'd4;
    localparam int               RSHIFT_BIT = 5;

    // Row key table: bit p of a row word is the p-th code of that row.
    localparam int ROW_COUNT = 5;
    localparam int ROW_KEYS  = 13;

    localparam logic [CODE_W-1:0] ROW_CODES [ROW_COUNT][ROW_KEYS] = '{
        '{8'h16, 8'h1E, 8'h26, 8'h25, 8'h2E, 8'h36, 8'h3D, 8'h3E, 8'h46, 8'h45, 8'h4E,
          8'h55, 8'h66},
        '{8'h0D, 8'h15, 8'h1D, 8'h24, 8'h2D, 8'h2C, 8'h35, 8'h3C, 8'h43, 8'h44, 8'h4D,
          8'h54, 8'h5B},
        '{8'h1C, 8'h1B, 8'h23, 8'h2B, 8'h34, 8'h33, 8'h3B, 8'h42, 8'h4B, 8'h4C, 8'h52,
          8'h5D, 8'h5A},
        '{8'h29, 8'h61, 8'h1A, 8'h22, 8'h21, 8'h2A, 8'h32, 8'h31, 8'h3A, 8'h41, 8'h49,
          8'h4A, 8'h00},
        '{8'hEB, 8'hF4, 8'hF5, 8'hF2, 8'h14, 8'h12, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00}
    };

    localparam logic [3:0] ROW_LENGTHS [ROW_COUNT] = '{4'd13, 4'd13, 4'd13, 4'd12, 4'd6};

endpackage

// ----- hdl/ps2_scancode_keyboard_matrix.sv -----
// Top level of the PS/2 set-2 scan code key matrix.
// Uses ps2km_pkg and ps2km_row_read.
//
//  Channel  Dir  Handshake          Contents
//  s_       in   s_tvalid/s_tready  tuser: opcode; tdata: code_byte, row_index
//  m_       out  m_tvalid/m_tready  tdata: row_bits, reset_request, last_key
//
// Each item's state update and result are both written at the accepting edge,
// so the result is shown the cycle after acceptance.
// One item is accepted per cycle, a rate set by the single output register,
// while that register is empty or being read; an unread result stalls input.
// Reset clears the KEY_MAP_DEPTH-bit key map, prefix flags and last key at once.
module ps2_scancode_keyboard_matrix
    import ps2km_pkg::*;
#(
    parameter int KEY_MAP_DEPTH = KEY_MAP_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,   // [0] opcode
    input  logic [15:0] s_tdata,   // [7:0] code_byte, [10:8] row_index, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [12:0] row_bits, [13] reset_request,
                                   // [22:14] last_key, [23] zero
);

    localparam int KEY_W = $clog2(KEY_MAP_DEPTH);

    logic [KEY_MAP_DEPTH-1:0]    key_map_reg, key_map_next;
    logic                        ext_pending_reg, ext_pending_next;
    logic                        rel_pending_reg, rel_pending_next;
    logic signed [LAST_KEY_W-1:0] last_key_reg, last_key_next;

    logic                        out_valid_reg;
    logic [ROW_BITS_W-1:0]       out_row_bits_reg;
    logic                        out_reset_req_reg;

    logic                        accept;
    logic                        opcode;
    logic [CODE_W-1:0]           code_byte;
    logic [ROW_W-1:0]            row_index;
    logic [CODE_W-1:0]           key;
    logic [ROW_BITS_W-1:0]       row_bits;

    // Input fields.
    assign opcode    = s_tuser;
    assign code_byte = s_tdata[7:0];
    assign row_index = s_tdata[10:8];

    // Take an item when the result register is free or being emptied.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Mapped key: low seven bits, upper half when an extended prefix is armed.
    assign key = (code_byte & KEY_LOW_MASK) | (ext_pending_reg ? KEY_EXT_BIT : CODE_NONE);

    // Next state for a code item.
    always_comb begin
        key_map_next     = key_map_reg;
        ext_pending_next = ext_pending_reg;
        rel_pending_next = rel_pending_reg;
        last_key_next    = last_key_reg;
        if (accept && opcode == OP_CODE && code_byte != CODE_NONE) begin
            if (code_byte == CODE_EXTENDED) begin
                ext_pending_next = 1'b1;
            end else if (code_byte == CODE_RELEASE) begin
                rel_pending_next = 1'b1;
            end else begin
                key_map_next[KEY_W'(key)] = !rel_pending_reg;
                if (rel_pending_reg) begin
                    last_key_next = LAST_KEY_W'(0) - $signed({1'b0, key});
                end else begin
                    last_key_next = $signed({1'b0, key});
                end
                ext_pending_next = 1'b0;
                rel_pending_next = 1'b0;
            end
        end
    end

    // Row lookup on the current map; a row read never changes the map.
    ps2km_row_read #(
        .KEY_MAP_DEPTH(KEY_MAP_DEPTH)
    ) u_row_read (
        .key_map  (key_map_reg),
        .row_index(row_index),
        .row_bits (row_bits)
    );

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_map_reg     <= '0;
            ext_pending_reg <= 1'b0;
            rel_pending_reg <= 1'b0;
            last_key_reg    <= '0;
        end else begin
            key_map_reg     <= key_map_next;
            ext_pending_reg <= ext_pending_next;
            rel_pending_reg <= rel_pending_next;
            last_key_reg    <= last_key_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload, taken from the state after this item's update.
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_row_bits_reg  <= (opcode == OP_ROW) ? row_bits : '0;
            out_reset_req_reg <= key_map_next[KEY_W'(KEY_CTRL)] &&
                                 key_map_next[KEY_W'(KEY_ESC)];
        end
    end

    // The last key in the result always equals the stored last key.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, last_key_reg, out_reset_req_reg, out_row_bits_reg};

    // An extended prefix arms the flag for the next code.
    a_ext_arm: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && opcode == OP_CODE && code_byte == CODE_EXTENDED) |=> ext_pending_reg)
        else $error("extended prefix did not arm the flag");

    // A row read leaves the key map and last key alone.
    a_row_no_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && opcode == OP_ROW) |=> ($stable(key_map_reg) && $stable(last_key_reg)))
        else $error("row read changed the key state");

    // A code item reports an empty row word.
    a_code_row_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && opcode == OP_CODE) |=> (m_tvalid && out_row_bits_reg == '0))
        else $error("code item gave nonzero row bits");

    // A shown reset request agrees with the held map.
    a_reset_req: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reset_req_reg) |->
            (key_map_reg[KEY_W'(KEY_CTRL)] && key_map_reg[KEY_W'(KEY_ESC)]))
        else $error("reset request without Ctrl and Esc held");

endmodule

// ----- hdl/ps2km_row_read.sv -----
// Row packer for the PS/2 key matrix: gathers the key-down bits of one row.
// Purely combinational; uses ps2km_pkg for the row key table.
module ps2km_row_read
    import ps2km_pkg::*;
#(
    parameter int KEY_MAP_DEPTH = KEY_MAP_DEPTH_DEF
) (
    input  logic [KEY_MAP_DEPTH-1:0] key_map,
    input  logic [ROW_W-1:0]         row_index,
    output logic [ROW_BITS_W-1:0]    row_bits
);

    localparam int KEY_W = $clog2(KEY_MAP_DEPTH);

    // Each bit within the row's length looks up a fixed map entry; other bits
    // and rows past the table read as zero.
    always_comb begin
        row_bits = '0;
        for (int r = 0; r < ROW_COUNT; r++) begin
            if (row_index == ROW_W'(r)) begin
                for (int p = 0; p < ROW_KEYS; p++) begin
                    if (p < int'(ROW_LENGTHS[r])) begin
                        row_bits[p] = key_map[KEY_W'(ROW_CODES[r][p])];
                    end
                end
            end
        end
        // Right shift is folded into the last row.
        if (row_index == RSHIFT_ROW && key_map[KEY_W'(KEY_RSHIFT)]) begin
            row_bits[RSHIFT_BIT] = 1'b1;
        end
    end

endmodule
